>>> rtl/core/rtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_pkg
// types and constants of the retransmit timer table
// ----------------------------------------------------------------------------
package rtt_pkg;

	// field widths
	localparam int NumW     = 32;
	localparam int TimeW    = 32;
	localparam int GapW     = 16;
	localparam int RetryW   = 8;
	localparam int ModeW    = 2;
	localparam int KindW    = 3;

	// stream payload widths
	localparam int InDataW  = 64;
	localparam int OutDataW = 48;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 16;

	// register reset values
	localparam logic [GapW-1:0]   GapReset   = 16'd1000;
	localparam logic [RetryW-1:0] RetryReset = 8'd5;

	// slot reduction of a packet number: one hex digit per cycle
	localparam int DigitW   = 4;
	localparam int ModSteps = NumW / DigitW;
	localparam int StepW    = $clog2(ModSteps);

	// register indexes
	localparam logic [CfgIdxW-1:0] CfgWaitGap    = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgMaxRetries = 1'd1;

	typedef enum logic [ModeW-1:0] {
		ModeRegister   = 2'd0,
		ModeUnregister = 2'd1,
		ModeTick       = 2'd2,
		ModeQuery      = 2'd3
	} mode_t;

	typedef enum logic [KindW-1:0] {
		KindAssigned  = 3'd0,
		KindResend    = 3'd1,
		KindQuery     = 3'd2,
		KindTickDone  = 3'd3,
		KindUnregDone = 3'd4
	} kind_t;

	typedef struct packed {
		logic [NumW-1:0]   number;
		logic [TimeW-1:0]  sent_time;
		logic [RetryW-1:0] retries;
	} entry_t;

endpackage

>>> rtl/core/retransmit_timer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retransmit_timer_table_unit
// table of pending retransmission timers with register, unregister, query
// and a timed resend scan
// ----------------------------------------------------------------------------
//
// channel   dir   transaction carries
// s_axis    in    tuser mode, tdata packet_number and now
// m_axis    out   tuser kind, tdata packet_number_res, retry_count, found;
//                 tlast on the final result of an input transaction
// cfg       in    one register write per cycle with cfg_we high
//
// steps: register inserts at the counter slot; unregister and query reduce
// the slot index from the packet number one hex digit per cycle, then read
// the entry memory and answer; tick visits each slot in the read state, an
// occupied slot also in the evaluate state, and ends with the done result
// reset: valid bits, counter, registers and output register clear at once,
// no clearing pass
// stalls: a held result stalls the block only where it must load the next
// result; slot reduction, entry reads and scanning past entries that are not
// due go on; a new input transaction is taken only after all results of the
// previous one are loaded
// ----------------------------------------------------------------------------
module retransmit_timer_table_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [rtt_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [rtt_pkg::CfgDataW-1:0]   cfg_data,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rtt_pkg::InDataW-1:0]    s_axis_tdata,   // packet_number, now
	input  logic [rtt_pkg::ModeW-1:0]      s_axis_tuser,   // mode
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rtt_pkg::OutDataW-1:0]   m_axis_tdata,   // packet_number_res,
	                                                       // retry_count, found
	output logic [rtt_pkg::KindW-1:0]      m_axis_tuser,   // kind
	output logic                           m_axis_tlast    // last
);

	import rtt_pkg::*;

	localparam int SlotW = $clog2(TABLE_DEPTH);
	localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_DEPTH - 1);
	localparam logic [SlotW:0]   DepthW   = (SlotW + 1)'(TABLE_DEPTH);
	localparam logic [StepW-1:0] LastStep = StepW'(ModSteps - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REG,    // insert at the counter slot
		S_MOD,    // reduce packet number to a slot index
		S_LREAD,  // read entry for unregister or query
		S_LEVAL,  // compare and answer
		S_TREAD,  // tick scan: read slot
		S_TEVAL,  // tick scan: age check, restamp and resend
		S_TDONE   // tick done result
	} state_t;

	state_t state_q;

	// configuration registers
	logic [GapW-1:0]   gap_q;
	logic [RetryW-1:0] max_q;

	// captured input transaction
	mode_t             mode_q;
	logic [NumW-1:0]   num_q;
	logic [TimeW-1:0]  now_q;
	logic [NumW-1:0]   digits_q;
	logic [StepW-1:0]  step_q;
	logic [SlotW-1:0]  slot_q;

	// number counter and its slot, kept in step so no reduction is needed
	logic [NumW-1:0]   next_number_q;
	logic [SlotW-1:0]  next_slot_q;

	// valid bit per slot, entry contents in memory
	logic [TABLE_DEPTH-1:0] valid_q;
	entry_t                 mem [TABLE_DEPTH];
	entry_t                 rd_q;

	// output register
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [NumW-1:0]   out_num_q;
	logic [RetryW-1:0] out_retry_q;
	logic              out_found_q;
	logic              out_last_q;

	logic              can_load;
	logic              mem_re;
	logic              mem_we;
	logic [SlotW-1:0]  wr_addr;
	entry_t            wr_data;
	logic [TimeW-1:0]  elapsed;
	logic              tick_due;
	logic              hit;
	logic [SlotW-1:0]  rem_next;
	logic [RetryW-1:0] retry_inc;

	assign can_load      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// resend check on the entry just read
	assign elapsed   = now_q - rd_q.sent_time;
	assign tick_due  = (elapsed > {{(TimeW - GapW){1'b0}}, gap_q}) && (rd_q.retries < max_q);
	assign retry_inc = rd_q.retries + 1'b1;
	assign hit       = valid_q[slot_q] && (rd_q.number == num_q);

	// slot remainder: fold in the next hex digit, one conditional subtract per bit
	always_comb begin
		logic [SlotW:0]   t;
		logic [SlotW-1:0] r;
		r = slot_q;
		for (int k = 0; k < DigitW; k++) begin
			t = {r, digits_q[NumW-1-k]};
			if (t >= DepthW) begin
				t = t - DepthW;
			end
			r = t[SlotW-1:0];
		end
		rem_next = r;
	end

	// memory port control
	always_comb begin
		mem_re  = (state_q == S_LREAD) || ((state_q == S_TREAD) && valid_q[slot_q]);
		mem_we  = 1'b0;
		wr_addr = slot_q;
		wr_data = '{number: rd_q.number, sent_time: now_q, retries: retry_inc};
		case (state_q)
			S_REG: begin
				mem_we  = can_load && !valid_q[next_slot_q];
				wr_addr = next_slot_q;
				wr_data = '{number: next_number_q, sent_time: now_q, retries: '0};
			end
			S_TEVAL: begin
				mem_we = can_load && tick_due;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_q <= mem[slot_q];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GapReset;
			max_q <= RetryReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgWaitGap:    gap_q <= cfg_data;
				CfgMaxRetries: max_q <= cfg_data[RetryW-1:0];
				default:       gap_q <= gap_q;
			endcase
		end
	end

	// input capture registers, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_q   <= mode_t'(s_axis_tuser);
			num_q    <= s_axis_tdata[NumW-1:0];
			now_q    <= s_axis_tdata[NumW +: TimeW];
			digits_q <= s_axis_tdata[NumW-1:0];
		end else if (state_q == S_MOD) begin
			digits_q <= {digits_q[NumW-1-DigitW:0], {DigitW{1'b0}}};
		end
	end

	// control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			slot_q        <= '0;
			next_number_q <= '0;
			next_slot_q   <= '0;
			valid_q       <= '0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= KindAssigned;
			out_num_q     <= '0;
			out_retry_q   <= '0;
			out_found_q   <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						slot_q <= '0;
						step_q <= '0;
						case (mode_t'(s_axis_tuser))
							ModeRegister: state_q <= S_REG;
							ModeTick:     state_q <= S_TREAD;
							default:      state_q <= S_MOD;
						endcase
					end
				end
				S_REG: begin
					if (can_load) begin
						// a busy slot refuses the insert, the number is spent anyway
						if (!valid_q[next_slot_q]) begin
							valid_q[next_slot_q] <= 1'b1;
						end
						out_valid_q   <= 1'b1;
						out_kind_q    <= KindAssigned;
						out_num_q     <= next_number_q;
						out_retry_q   <= '0;
						out_found_q   <= !valid_q[next_slot_q];
						out_last_q    <= 1'b1;
						next_number_q <= next_number_q + 1'b1;
						// counter wrap restarts the slot sequence at zero
						if (next_number_q == {NumW{1'b1}} || next_slot_q == LastSlot) begin
							next_slot_q <= '0;
						end else begin
							next_slot_q <= next_slot_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_MOD: begin
					slot_q <= rem_next;
					step_q <= step_q + 1'b1;
					if (step_q == LastStep) begin
						state_q <= S_LREAD;
					end
				end
				S_LREAD: begin
					state_q <= S_LEVAL;
				end
				S_LEVAL: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_num_q   <= num_q;
						out_found_q <= hit;
						out_last_q  <= 1'b1;
						if (mode_q == ModeUnregister) begin
							out_kind_q  <= KindUnregDone;
							out_retry_q <= '0;
							if (hit) begin
								valid_q[slot_q] <= 1'b0;
							end
						end else begin
							out_kind_q  <= KindQuery;
							out_retry_q <= hit ? rd_q.retries : '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_TREAD: begin
					if (valid_q[slot_q]) begin
						state_q <= S_TEVAL;
					end else if (slot_q == LastSlot) begin
						state_q <= S_TDONE;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_TEVAL: begin
					// a due entry waits here until the result can be loaded
					if (!tick_due || can_load) begin
						if (tick_due) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KindResend;
							out_num_q   <= rd_q.number;
							out_retry_q <= retry_inc;
							out_found_q <= 1'b1;
							out_last_q  <= 1'b0;
						end
						if (slot_q == LastSlot) begin
							state_q <= S_TDONE;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_TREAD;
						end
					end
				end
				S_TDONE: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KindTickDone;
						out_num_q   <= '0;
						out_retry_q <= '0;
						out_found_q <= 1'b0;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(OutDataW - NumW - RetryW - 1){1'b0}},
	                        out_found_q, out_retry_q, out_num_q};

`ifndef NO_ASSERTIONS
	// one input transaction at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a transaction is in flight");

	// resends never close a transaction, every other result does
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KindResend)))
		else $error("tlast does not match result kind");

	// slot indexes stay inside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(slot_q <= LastSlot) && (next_slot_q <= LastSlot))
		else $error("slot index beyond table depth");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the retransmit timer table: a queue-fed stream
// driver with bursty gaps, a stalling result sink, and a shadow copy of the
// timer table that works out every result and compares it field by field
// ----------------------------------------------------------------------------
module tb_top;
	import rtt_pkg::*;

	localparam int DEPTH         = 16;
	localparam int SETTLE_CYCLES = 40;      // settle wait, no shorter than the longest tick scan
	localparam int LONG_HOLD     = 300;     // receiver hold-off while the sender pushes
	localparam int RUN_LIMIT     = 400000;

	// one input transaction: mode in tuser, {now, packet_number} in tdata
	typedef struct packed {
		mode_t            mode;
		logic [NumW-1:0]  number;
		logic [TimeW-1:0] now;
	} timer_cmd_t;

	// one result transaction as it should leave the block
	typedef struct packed {
		kind_t             kind;
		logic [NumW-1:0]   number;
		logic [RetryW-1:0] retries;
		logic              found;
		logic              last;
	} timer_result_t;

	// clock and reset
	logic clk;
	logic arst_n = 1'b0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// block ports
	logic                cfg_we        = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index     = CfgWaitGap;
	logic [CfgDataW-1:0] cfg_data      = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata  = '0;   // packet_number, now
	logic [ModeW-1:0]    s_axis_tuser  = ModeRegister;   // mode
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;         // packet_number_res, retry_count, found
	logic [KindW-1:0]    m_axis_tuser;         // kind
	logic                m_axis_tlast;

	retransmit_timer_table_unit #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// stimulus and scoreboard storage
	timer_cmd_t    queued_commands[$];
	timer_result_t awaited_results[$];
	logic [NumW-1:0] issued_numbers[$];   // recent numbers handed out, for hits
	logic [NumW-1:0] gen_next_number = '0;
	logic [TimeW-1:0] gen_now = '0;

	// shadow of the block state
	logic              shadow_valid[DEPTH];
	entry_t            shadow_entry[DEPTH];
	logic [NumW-1:0]   shadow_next_number = '0;
	logic [GapW-1:0]   shadow_wait_gap    = GapReset;
	logic [RetryW-1:0] shadow_retry_limit = RetryReset;

	int mismatch_count = 0;
	int results_seen   = 0;
	int cycle_count    = 0;
	int hold_requests  = 0;
	int holds_served   = 0;
	int hold_left      = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int pattern_age    = 0;
	logic [7:0] ready_pattern = 8'hFF;
	logic in_taken = 1'b0;

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_entry[i] = '0;
		end
	end

	task automatic report_mismatch(input string what, input logic [NumW-1:0] got,
			input logic [NumW-1:0] want);
		$display("result %0d: %s is %0h, want %0h (t=%0t)", results_seen, what, got, want,
			$realtime);
		mismatch_count++;
	endtask

	function automatic void await_result(input kind_t k, input logic [NumW-1:0] n,
			input logic [RetryW-1:0] r, input logic f, input logic l);
		timer_result_t res;
		res.kind    = k;
		res.number  = n;
		res.retries = r;
		res.found   = f;
		res.last    = l;
		awaited_results.push_back(res);
	endfunction

	// works out the results of one accepted transaction and updates the shadow
	task automatic model_timer_table(input timer_cmd_t cmd);
		int unsigned slot;
		logic hit;
		logic [TimeW-1:0] age;
		slot = cmd.number % DEPTH;
		hit  = shadow_valid[slot] && (shadow_entry[slot].number == cmd.number);
		case (cmd.mode)
			ModeRegister: begin
				slot = shadow_next_number % DEPTH;
				if (shadow_valid[slot]) begin
					// occupied slot: refused, the number is used up anyway
					await_result(KindAssigned, shadow_next_number, '0, 1'b0, 1'b1);
				end else begin
					shadow_valid[slot]           = 1'b1;
					shadow_entry[slot].number    = shadow_next_number;
					shadow_entry[slot].sent_time = cmd.now;
					shadow_entry[slot].retries   = '0;
					await_result(KindAssigned, shadow_next_number, '0, 1'b1, 1'b1);
				end
				shadow_next_number = shadow_next_number + 1'b1;
			end
			ModeUnregister: begin
				if (hit)
					shadow_valid[slot] = 1'b0;
				await_result(KindUnregDone, cmd.number, '0, hit, 1'b1);
			end
			ModeTick: begin
				for (int i = 0; i < DEPTH; i++) begin
					age = cmd.now - shadow_entry[i].sent_time;   // wraps at 2^32
					if (shadow_valid[i] && age > TimeW'(shadow_wait_gap)
							&& shadow_entry[i].retries < shadow_retry_limit) begin
						shadow_entry[i].retries   = shadow_entry[i].retries + 1'b1;
						shadow_entry[i].sent_time = cmd.now;
						await_result(KindResend, shadow_entry[i].number,
							shadow_entry[i].retries, 1'b1, 1'b0);
					end
				end
				await_result(KindTickDone, '0, '0, 1'b0, 1'b1);
			end
			default: begin
				await_result(KindQuery, cmd.number, hit ? shadow_entry[slot].retries : '0,
					hit, 1'b1);
			end
		endcase
	endtask

	// driver: bursts of random length, random gaps, new data at the falling edge
	always @(negedge clk) begin
		logic offer;
		timer_cmd_t cmd;
		offer = s_axis_tvalid && !in_taken;
		if (arst_n && !offer) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (queued_commands.size() != 0) begin
				cmd = queued_commands.pop_front();
				s_axis_tdata <= {cmd.now, cmd.number};
				s_axis_tuser <= cmd.mode;
				offer = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					// a quarter of the bursts run straight into the next
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
		s_axis_tvalid <= offer;
	end

	// result sink: a rotating ready pattern, now and then a long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (arst_n) begin
			if (pattern_age == 0) begin
				ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
				pattern_age   = $urandom_range(20, 80);
			end else begin
				pattern_age--;
			end
			ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
			m_axis_tready <= ready_pattern[0];
		end
	end

	// monitor: predicts on an input transaction, checks on a result transaction
	always @(posedge clk) begin
		timer_result_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				model_timer_table({mode_t'(s_axis_tuser), s_axis_tdata[NumW-1:0],
					s_axis_tdata[InDataW-1:NumW]});
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unrequested result, number", m_axis_tdata[NumW-1:0], '0);
				end else begin
					want = awaited_results.pop_front();
					if (m_axis_tuser !== want.kind)
						report_mismatch("kind", NumW'(m_axis_tuser), NumW'(want.kind));
					if (m_axis_tdata[NumW-1:0] !== want.number)
						report_mismatch("packet number", m_axis_tdata[NumW-1:0], want.number);
					if (m_axis_tdata[NumW+RetryW-1:NumW] !== want.retries)
						report_mismatch("retry count", NumW'(m_axis_tdata[NumW+RetryW-1:NumW]),
							NumW'(want.retries));
					if (m_axis_tdata[NumW+RetryW] !== want.found)
						report_mismatch("found", NumW'(m_axis_tdata[NumW+RetryW]),
							NumW'(want.found));
					if (m_axis_tlast !== want.last)
						report_mismatch("last", NumW'(m_axis_tlast), NumW'(want.last));
				end
				// zero fill above the found bit
				if (m_axis_tdata[OutDataW-1:NumW+RetryW+1] !== '0)
					report_mismatch("tdata fill", NumW'(m_axis_tdata[OutDataW-1:NumW+RetryW+1]),
						'0);
				results_seen++;
			end
		end
	end

	// run limit
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// register write, only issued while the block is idle
	task automatic write_register(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgWaitGap)
			shadow_wait_gap = value;
		else
			shadow_retry_limit = value[RetryW-1:0];
	endtask

	task automatic queue_command(input mode_t m, input logic [NumW-1:0] n,
			input logic [TimeW-1:0] t);
		timer_cmd_t cmd;
		cmd.mode   = m;
		cmd.number = n;
		cmd.now    = t;
		if (m == ModeRegister) begin
			issued_numbers.push_back(gen_next_number);
			if (issued_numbers.size() > 24)
				issued_numbers.delete(0);
			gen_next_number = gen_next_number + 1'b1;
		end
		queued_commands.push_back(cmd);
	endtask

	// mostly live numbers for unregister and query, time moving forward by
	// up to step_max with an occasional jump anywhere
	task automatic queue_random_commands(input int count, input int unsigned step_max);
		int unsigned pick;
		mode_t m;
		logic [NumW-1:0] n;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				m = ModeRegister;
			else if (pick < 60)
				m = ModeTick;
			else if (pick < 80)
				m = ModeQuery;
			else
				m = ModeUnregister;
			if ($urandom_range(0, 15) == 0)
				gen_now = $urandom;
			else
				gen_now = gen_now + $urandom_range(0, step_max);
			n = $urandom;
			if ((m == ModeQuery || m == ModeUnregister) && issued_numbers.size() != 0
					&& $urandom_range(0, 9) < 7)
				n = issued_numbers[$urandom_range(0, issued_numbers.size() - 1)];
			queue_command(m, n, (m == ModeRegister || m == ModeTick) ? gen_now : $urandom);
		end
	endtask

	// sender stops until every awaited result is in, then the block settles
	task automatic wait_for_idle();
		while (queued_commands.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [GapW-1:0] gap_pick;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part with the reset settings: gap 1000, five retries
		queue_command(ModeQuery, 32'd0, $urandom);              // empty table
		queue_command(ModeUnregister, 32'hFFFF_FFFF, $urandom); // absent number
		queue_command(ModeTick, $urandom, 32'd0);               // nothing to scan
		queue_command(ModeRegister, $urandom, 32'hFFFF_FF00);   // number 0
		queue_command(ModeRegister, 32'hFFFF_FFFF, 32'd5);      // number 1
		queue_command(ModeRegister, 32'd0, 32'd0);              // number 2
		queue_command(ModeQuery, 32'd0, 32'd0);
		queue_command(ModeQuery, 32'd1, 32'hFFFF_FFFF);
		queue_command(ModeTick, 32'd0, 32'h0000_02E8);          // age of number 0 equals gap
		queue_command(ModeTick, 32'd0, 32'h0000_02E9);          // one past the gap, across wrap
		queue_command(ModeTick, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // every entry due
		queue_command(ModeTick, 32'd0, 32'h0000_1000);
		queue_command(ModeTick, 32'd0, 32'h0000_2000);
		queue_command(ModeTick, 32'd0, 32'h0000_3000);
		queue_command(ModeTick, 32'd0, 32'h0000_4000);          // number 0 exhausted
		queue_command(ModeTick, 32'd0, 32'h0000_5000);          // all exhausted, kept
		queue_command(ModeQuery, 32'd0, 32'd0);
		queue_command(ModeUnregister, 32'd1, 32'd0);
		queue_command(ModeQuery, 32'd1, 32'd0);
		queue_command(ModeUnregister, 32'd1, 32'd0);            // already gone
		queue_command(ModeQuery, 32'd16, 32'd0);                // same slot, other number
		gen_now = 32'h0000_5000;
		queue_random_commands(38, 2500);
		wait_for_idle();

		// no gap, no retries: nothing is ever resent
		write_register(CfgWaitGap, 16'd0);
		write_register(CfgMaxRetries, 16'd0);
		queue_random_commands(45, 3);
		wait_for_idle();

		// widest settings, with a long receiver hold-off up front
		write_register(CfgWaitGap, 16'hFFFF);
		write_register(CfgMaxRetries, 16'd255);
		hold_requests++;
		queue_random_commands(60, 140000);
		wait_for_idle();

		// zero gap and small steps across the time wrap
		write_register(CfgWaitGap, 16'd0);
		write_register(CfgMaxRetries, 16'd3);
		gen_now = 32'hFFFF_FFC0;
		queue_random_commands(70, 2);
		wait_for_idle();

		// random middle settings
		gap_pick = GapW'($urandom_range(1, 3000));
		write_register(CfgWaitGap, gap_pick);
		write_register(CfgMaxRetries, 16'($urandom_range(1, 8)));
		queue_random_commands(80, 2 * gap_pick + 2);
		wait_for_idle();

		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
